>>> design/adsr_envelope_generator_macros.svh
// ---------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

// cond holds in the same cycle as trig
`define ADSR_ASSERT_SAME(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("adsr assertion failed");

// cond holds in the cycle after trig
`define ADSR_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("adsr assertion failed");

`endif

>>> design/adsr_pkg.sv
// ---------------------------------------------------------------------------
// adsr_pkg
// Types, codes and constants shared by the ADSR envelope generator.
// ---------------------------------------------------------------------------
package adsr_pkg;

   localparam int AMP_WIDTH  = 16;
   localparam int TIME_WIDTH = 8;
   localparam int STEP_WIDTH = 16;
   localparam int CSR_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // product of a step and an elapsed time, plus one bit for the ramp sums
   localparam int PROD_WIDTH = STEP_WIDTH + TIME_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;

   // 0.0001 full scale, truncated
   localparam logic [AMP_WIDTH-1:0] AMP_FLOOR =
      AMP_WIDTH'((64'd1 << AMP_WIDTH) / 64'd10000);

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_GATE_ON  = 2'd1,
      OP_GATE_OFF = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      PH_INACTIVE = 3'd0,
      PH_ATTACK   = 3'd1,
      PH_DECAY    = 3'd2,
      PH_SUSTAIN  = 3'd3,
      PH_RELEASE  = 3'd4
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTACK_LEVEL   = 3'd0,
      CSR_SUSTAIN_LEVEL  = 3'd1,
      CSR_ATTACK_STEP    = 3'd2,
      CSR_DECAY_STEP     = 3'd3,
      CSR_RELEASE_STEP   = 3'd4,
      CSR_SUSTAIN_ENABLE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [TIME_WIDTH-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [AMP_WIDTH-1:0] amplitude;
      phase_type            phase;
   } rsp_type;

   typedef struct packed {
      logic [AMP_WIDTH-1:0]  attack_level;
      logic [AMP_WIDTH-1:0]  sustain_level;
      logic [STEP_WIDTH-1:0] attack_step;
      logic [STEP_WIDTH-1:0] decay_step;
      logic [STEP_WIDTH-1:0] release_step;
      logic                  sustain_enable;
   } cfg_type;

   typedef struct packed {
      logic [AMP_WIDTH-1:0] level;
      phase_type            phase;
      logic                 gate_held;
   } env_state_type;

endpackage

>>> design/adsr_csr.sv
// ---------------------------------------------------------------------------
// adsr_csr
// Configuration registers, written through a plain indexed write port.
// ---------------------------------------------------------------------------
module adsr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [adsr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [adsr_pkg::CSR_WIDTH-1:0]       csr_write_data,
   output adsr_pkg::cfg_type                    cfg
);

   adsr_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (adsr_pkg::csr_index_type'(csr_index))
            adsr_pkg::CSR_ATTACK_LEVEL:   cfg_ff.attack_level   <= csr_write_data;
            adsr_pkg::CSR_SUSTAIN_LEVEL:  cfg_ff.sustain_level  <= csr_write_data;
            adsr_pkg::CSR_ATTACK_STEP:    cfg_ff.attack_step    <= csr_write_data;
            adsr_pkg::CSR_DECAY_STEP:     cfg_ff.decay_step     <= csr_write_data;
            adsr_pkg::CSR_RELEASE_STEP:   cfg_ff.release_step   <= csr_write_data;
            adsr_pkg::CSR_SUSTAIN_ENABLE: cfg_ff.sustain_enable <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/adsr_step.sv
// ---------------------------------------------------------------------------
// adsr_step
// Next envelope state for one item: one ramp multiply, add and clamp.
// ---------------------------------------------------------------------------
module adsr_step (
   input  adsr_pkg::req_type       item,
   input  adsr_pkg::env_state_type state,
   input  adsr_pkg::cfg_type       cfg,
   output adsr_pkg::env_state_type next_state
);

   logic [adsr_pkg::STEP_WIDTH-1:0] step_sel;
   logic [adsr_pkg::PROD_WIDTH-1:0] ramp;
   logic [adsr_pkg::SUM_WIDTH-1:0]  level_ext;
   logic [adsr_pkg::SUM_WIDTH-1:0]  ramp_ext;
   logic [adsr_pkg::SUM_WIDTH-1:0]  up_sum;
   logic [adsr_pkg::SUM_WIDTH-1:0]  decay_bound;
   logic [adsr_pkg::AMP_WIDTH-1:0]  ramp_level;
   logic [adsr_pkg::AMP_WIDTH-1:0]  ramp_out;
   adsr_pkg::phase_type             tick_phase;

   always_comb begin
      unique case (state.phase)
         adsr_pkg::PH_ATTACK: step_sel = cfg.attack_step;
         adsr_pkg::PH_DECAY:  step_sel = cfg.decay_step;
         default:             step_sel = cfg.release_step;
      endcase
   end

   assign ramp        = adsr_pkg::PROD_WIDTH'(step_sel) * adsr_pkg::PROD_WIDTH'(item.elapsed);
   assign level_ext   = adsr_pkg::SUM_WIDTH'(state.level);
   assign ramp_ext    = adsr_pkg::SUM_WIDTH'(ramp);
   assign up_sum      = level_ext + ramp_ext;
   assign decay_bound = ramp_ext + adsr_pkg::SUM_WIDTH'(cfg.sustain_level);
   // only used where ramp < level, so the low bits are the whole ramp
   assign ramp_level  = ramp[adsr_pkg::AMP_WIDTH-1:0];

   always_comb begin
      ramp_out   = state.level;
      tick_phase = state.phase;
      unique case (state.phase)
         adsr_pkg::PH_ATTACK: begin
            if (up_sum >= adsr_pkg::SUM_WIDTH'(cfg.attack_level)) begin
               ramp_out   = cfg.attack_level;
               tick_phase = adsr_pkg::PH_DECAY;
            end else begin
               ramp_out = up_sum[adsr_pkg::AMP_WIDTH-1:0];
            end
         end
         adsr_pkg::PH_DECAY: begin
            if (level_ext <= decay_bound) begin
               ramp_out   = cfg.sustain_level;
               tick_phase = adsr_pkg::PH_SUSTAIN;
            end else begin
               ramp_out = state.level - ramp_level;
            end
         end
         adsr_pkg::PH_SUSTAIN: begin
            if (!state.gate_held) begin
               tick_phase = adsr_pkg::PH_RELEASE;
            end
         end
         adsr_pkg::PH_RELEASE: begin
            if (level_ext <= ramp_ext) begin
               ramp_out   = '0;
               tick_phase = adsr_pkg::PH_INACTIVE;
            end else begin
               ramp_out = state.level - ramp_level;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      next_state = state;
      unique case (item.opcode)
         adsr_pkg::OP_TICK: begin
            next_state.phase = tick_phase;
            next_state.level = (ramp_out <= adsr_pkg::AMP_FLOOR) ? '0 : ramp_out;
         end
         adsr_pkg::OP_GATE_ON: begin
            next_state.gate_held = cfg.sustain_enable;
            next_state.phase     = adsr_pkg::PH_ATTACK;
         end
         adsr_pkg::OP_GATE_OFF: begin
            next_state.gate_held = 1'b0;
         end
         default: ;
      endcase
   end

endmodule

>>> design/adsr_envelope_generator.sv
// ---------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope with Q0.16 amplitude, one result item per input item.
// ---------------------------------------------------------------------------
// Input items (req_) carry a tick with an elapsed time, a gate-on or a
// gate-off; each returns one result item (rsp_) with the amplitude and phase
// after that item. Both channels are valid/ready.
// An item is registered in the input register on accept; once the output
// register is free, it runs through the step logic (one 16 x 8 multiply,
// an add and a clamp compare) into the output register, updating the
// envelope state at the same edge, and rsp_valid rises.
// Throughput is one item per cycle while the receiver does not stall; the
// envelope state loop closes within that single step stage.
// While the receiver stalls, the output register holds its item and the
// input register takes one more; req_ready drops only when both are full.
// Reset clears the envelope to inactive at zero amplitude, the held gate and
// all configuration registers. The csr_ port writes a register at any edge
// with csr_write_enable high; write it only while no item is in flight.
// ---------------------------------------------------------------------------
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  adsr_pkg::req_type                    req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output adsr_pkg::rsp_type                    rsp_item,
   input  logic                                 csr_write_enable,
   input  logic [adsr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [adsr_pkg::CSR_WIDTH-1:0]       csr_write_data
);

   adsr_pkg::cfg_type       cfg;
   adsr_pkg::env_state_type state_ff;
   adsr_pkg::env_state_type state_in;
   adsr_pkg::req_type       hold_item_ff;
   logic                    hold_valid_ff;
   adsr_pkg::rsp_type       rsp_item_ff;
   logic                    rsp_valid_ff;
   logic                    out_free;
   logic                    advance;
   logic                    req_accept;

   adsr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   adsr_step u_step (
      .item       (hold_item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .next_state (state_in)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = hold_valid_ff && out_free;
   assign req_ready  = !hold_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_accept) begin
         hold_valid_ff <= 1'b1;
      end else if (advance) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.level     <= '0;
         state_ff.phase     <= adsr_pkg::PH_INACTIVE;
         state_ff.gate_held <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff.amplitude <= state_in.level;
         rsp_item_ff.phase     <= state_in.phase;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `ADSR_ASSERT_SAME(a_inactive_is_silent, state_ff.phase == adsr_pkg::PH_INACTIVE, state_ff.level == '0)
   `ADSR_ASSERT_NEXT(a_stalled_item_holds, hold_valid_ff && !out_free, hold_valid_ff && $stable(hold_item_ff))
   `ADSR_ASSERT_NEXT(a_advance_gives_result, advance, rsp_valid_ff)

endmodule
